// ===== rtl/rie_pkg.sv =====
// Shared types, opcode codes and status codes for the integer execute unit.
// No dependencies.
package rie_pkg;

	typedef enum logic [2:0] {
		ST_CONTINUE = 3'd0,
		ST_DONE     = 3'd1,
		ST_SYSCALL  = 3'd2,
		ST_COP2     = 3'd3,
		ST_UNSUP    = 3'd4
	} status_t;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_REGIMM  = 6'h01;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_BLEZ    = 6'h06;
	localparam logic [5:0] OP_BGTZ    = 6'h07;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0A;
	localparam logic [5:0] OP_SLTIU   = 6'h0B;
	localparam logic [5:0] OP_ANDI    = 6'h0C;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_XORI    = 6'h0E;
	localparam logic [5:0] OP_LUI     = 6'h0F;
	localparam logic [5:0] OP_COP0    = 6'h10;
	localparam logic [5:0] OP_COP2    = 6'h12;
	localparam logic [5:0] OP_CACHE   = 6'h2F;

	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_SRA     = 6'h03;
	localparam logic [5:0] FN_SLLV    = 6'h04;
	localparam logic [5:0] FN_SRLV    = 6'h06;
	localparam logic [5:0] FN_SRAV    = 6'h07;
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [5:0] FN_JALR    = 6'h09;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_SYNC    = 6'h0F;
	localparam logic [5:0] FN_MFHI    = 6'h10;
	localparam logic [5:0] FN_MTHI    = 6'h11;
	localparam logic [5:0] FN_MFLO    = 6'h12;
	localparam logic [5:0] FN_MTLO    = 6'h13;
	localparam logic [5:0] FN_MULT    = 6'h18;
	localparam logic [5:0] FN_MULTU   = 6'h19;
	localparam logic [5:0] FN_DIV     = 6'h1A;
	localparam logic [5:0] FN_DIVU    = 6'h1B;
	localparam logic [5:0] FN_ADD     = 6'h20;
	localparam logic [5:0] FN_ADDU    = 6'h21;
	localparam logic [5:0] FN_SUB     = 6'h22;
	localparam logic [5:0] FN_SUBU    = 6'h23;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_XOR     = 6'h26;
	localparam logic [5:0] FN_NOR     = 6'h27;
	localparam logic [5:0] FN_SLT     = 6'h2A;
	localparam logic [5:0] FN_SLTU    = 6'h2B;

	localparam logic [4:0] RS_MF    = 5'h00;
	localparam logic [4:0] RS_MT    = 5'h04;
	localparam logic [4:0] RS_CO    = 5'h10;
	localparam logic [4:0] RT_BLTZ   = 5'h00;
	localparam logic [4:0] RT_BGEZ   = 5'h01;
	localparam logic [4:0] RT_BLTZAL = 5'h10;
	localparam logic [4:0] RT_BGEZAL = 5'h11;
	localparam logic [4:0] REG_RA   = 5'd31;
	localparam logic [4:0] CP0_SR   = 5'd12;
	localparam logic [5:0] FN_RFE   = 6'h10;

	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [31:0] instr_word;
		logic [31:0] instr_pc;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] next_pc;
		logic        reg_write;
		logic [4:0]  reg_index;
		logic [31:0] reg_value;
	} out_word_t;

	// classification carried from the front part to the back part
	typedef struct packed {
		logic        transfer;
		logic        is_mul;
		logic        is_div;
		logic        div_signed;
		logic [31:0] word;
		logic [31:0] pc;
	} dec_word_t;

	function automatic logic is_transfer(input logic [31:0] w);
		logic [5:0] op;
		op = w[31:26];
		return (op >= OP_REGIMM && op <= OP_BGTZ) ||
			(op == OP_SPECIAL && (w[5:0] == FN_JR || w[5:0] == FN_JALR));
	endfunction

	function automatic logic [31:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

// ===== rtl/r3000a_integer_execute_unit.sv =====
// Top level of the R3000A integer execute unit.
// Depends on rie_pkg, rie_front and rie_back.
//
// Input channel: drive an instruction word and its pc on in_word and raise push;
// the word is taken at a clock edge where push is high and full is low.
// Result channel: while empty is low the oldest result is on out_word; it is
// taken at an edge where pop is high.
// Every input word gives exactly one result word, in order.
// The front queue holds two words so the sender runs ahead of execution.
// Ordinary instructions pass through the queue, register read and execute;
// multiply and divide also wait for the one-bit-per-cycle iterative
// multiply/divide unit.
// The back part takes a new word only once its register-read and execute
// sequencer is back in its idle state.
// A result waits in the output register while pop is low; execution of the
// next word stalls only when it needs that register.
// Reset clears the queue, the branch state, HI, LO and the valid bits that make
// all general and COP0 registers read as zero.
module r3000a_integer_execute_unit import rie_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_word_t  in_word,
	output logic      empty,
	input  logic      pop,
	output out_word_t out_word
);

	logic      q_valid, q_take;
	dec_word_t q_data;

	rie_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_data(in_word),
		.q_valid(q_valid), .q_take(q_take), .q_data(q_data)
	);

	rie_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_take(q_take),
		.q_data(q_data), .empty(empty), .pop(pop), .out_data(out_word)
	);

endmodule

// ===== rtl/rie_front.sv =====
// Front part: accepts instruction words, classifies them, feeds a short queue.
// Depends on rie_pkg.
module rie_front import rie_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_word_t  in_data,
	output logic      q_valid,
	input  logic      q_take,
	output dec_word_t q_data
);

	localparam int PW = $clog2(QDEPTH);

	dec_word_t        mem_q [QDEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [PW:0]      cnt_q;
	dec_word_t        dec;
	logic             do_push, do_pop;

	// classify the incoming word
	always_comb begin
		dec.word       = in_data.instr_word;
		dec.pc         = in_data.instr_pc;
		dec.transfer   = is_transfer(in_data.instr_word);
		dec.is_mul     = in_data.instr_word[31:26] == OP_SPECIAL &&
			(in_data.instr_word[5:0] == FN_MULT || in_data.instr_word[5:0] == FN_MULTU);
		dec.is_div     = in_data.instr_word[31:26] == OP_SPECIAL &&
			(in_data.instr_word[5:0] == FN_DIV || in_data.instr_word[5:0] == FN_DIVU);
		dec.div_signed = in_data.instr_word[5:0] == FN_DIV ||
			in_data.instr_word[5:0] == FN_MULT;
	end

	assign full    = cnt_q == (PW+1)'(QDEPTH);
	assign q_valid = cnt_q != '0;
	assign q_data  = mem_q[rp_q];
	assign do_push = push && !full;
	assign do_pop  = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= dec;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + 1'b1;
			if (do_pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end

endmodule

// ===== rtl/rie_muldiv.sv =====
// Iterative multiply/divide unit: one bit per cycle over the 32-bit operands.
// Depends on rie_pkg.
module rie_muldiv import rie_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        is_div,
	input  logic        sgn,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] hi,
	output logic [31:0] lo
);

	logic        busy_q, div_q, nega_q, negr_q;
	logic [4:0]  cnt_q;
	logic [63:0] acc_q;
	logic [31:0] mag_b_q;
	logic [32:0] trial;
	logic [32:0] psum;
	logic [31:0] ma, mb, qv, rv;
	logic [63:0] pv;

	assign ma    = (sgn && a[31]) ? -a : a;
	assign mb    = (sgn && b[31]) ? -b : b;
	assign trial = {acc_q[63:31]} - {1'b0, mag_b_q};
	assign psum  = {1'b0, acc_q[63:32]} + ((acc_q[0]) ? {1'b0, mag_b_q} : 33'd0);

	// results with sign correction
	always_comb begin
		qv = acc_q[31:0];
		rv = acc_q[63:32];
		pv = acc_q;
		if (div_q) begin
			if (negr_q) qv = -qv;
			if (nega_q) rv = -rv;
			hi = rv;
			lo = qv;
		end else begin
			if (negr_q) pv = -pv;
			hi = pv[63:32];
			lo = pv[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= {32'd0, ma};
			mag_b_q <= mb;
			div_q   <= is_div;
			nega_q  <= sgn && a[31];
			negr_q  <= sgn && (a[31] ^ b[31]);
		end else if (busy_q) begin
			if (div_q) begin
				if (!trial[32]) acc_q <= {trial[31:0], acc_q[30:0], 1'b1};
				else            acc_q <= {acc_q[62:0], 1'b0};
			end else begin
				acc_q <= {psum, acc_q[31:1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/rie_back.sv =====
// Back part: register files, branch state and execution; owns the result register.
// Depends on rie_pkg and rie_muldiv.
module rie_back import rie_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_take,
	input  dec_word_t q_data,
	output logic      empty,
	input  logic      pop,
	output out_word_t out_data
);

	typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC, S_WAIT} state_t;

	state_t      state_q;
	logic [31:0] gpr_q [32];
	logic [31:0] cp0_q [32];
	logic [31:0] gpr_ok_q, cp0_ok_q;
	logic [31:0] hi_q, lo_q;
	logic        bp_q, bt_q;
	logic [31:0] btgt_q;
	dec_word_t   cur_q;
	logic [31:0] a_s1, b_s1, c0_s1;
	logic        out_v_q;

	logic [31:0] w, pc, a, b, simm, imm, pc4, pc8, rel;
	logic [5:0]  op, fn;
	logic [4:0]  rs, rt, rd, sa;
	status_t     st;
	logic        we, c0we, hiwe, lowe, arm, tk, md_start;
	logic [4:0]  widx;
	logic [31:0] wval, c0val, hival, loval, tgt, nxt;
	logic        md_done;
	logic [31:0] md_hi, md_lo;
	logic        out_free;
	logic        md_go, out_load;

	assign w  = cur_q.word;
	assign pc = cur_q.pc;
	assign op = w[31:26];
	assign rs = w[25:21];
	assign rt = w[20:16];
	assign rd = w[15:11];
	assign sa = w[10:6];
	assign fn = w[5:0];
	assign a  = a_s1;
	assign b  = b_s1;
	assign imm  = {16'd0, w[15:0]};
	assign simm = sext16(w[15:0]);
	assign pc4  = pc + 32'd4;
	assign pc8  = pc + 32'd8;
	assign rel  = pc4 + {simm[29:0], 2'b00};
	assign out_free = !out_v_q || pop;
	assign empty = !out_v_q;
	assign q_take = state_q == S_IDLE && q_valid;

	// start multiply/divide only once the result register is free
	assign md_go    = state_q == S_EXEC && md_start && out_free;
	assign out_load = (state_q == S_EXEC && out_free && !(md_start && st == ST_CONTINUE)) ||
		(state_q == S_WAIT && md_done);

	rie_muldiv u_md (
		.clk(clk), .arst_n(arst_n), .start(md_go), .is_div(cur_q.is_div),
		.sgn(cur_q.div_signed), .a(a), .b(b), .done(md_done), .hi(md_hi), .lo(md_lo)
	);

	// execute the current word
	always_comb begin
		st = ST_CONTINUE; we = 1'b0; widx = rd; wval = '0;
		c0we = 1'b0; c0val = b; hiwe = 1'b0; lowe = 1'b0; hival = a; loval = a;
		arm = 1'b0; tk = 1'b1; tgt = rel; md_start = 1'b0;
		if (bp_q && cur_q.transfer) begin
			st = ST_UNSUP;
		end else if (cur_q.transfer) begin
			unique case (op)
				OP_SPECIAL: begin
					tgt = a;
					if (fn == FN_JALR) begin
						we = 1'b1; widx = (rd != 5'd0) ? rd : REG_RA; wval = pc8;
					end
				end
				OP_J, OP_JAL: begin
					tgt = {pc4[31:28], w[25:0], 2'b00};
					if (op == OP_JAL) begin
						we = 1'b1; widx = REG_RA; wval = pc8;
					end
				end
				OP_REGIMM: begin
					if (rt == RT_BLTZ || rt == RT_BLTZAL)      tk = a[31];
					else if (rt == RT_BGEZ || rt == RT_BGEZAL) tk = !a[31];
					else                                       st = ST_UNSUP;
					if (rt == RT_BLTZAL || rt == RT_BGEZAL) begin
						we = 1'b1; widx = REG_RA; wval = pc8;
					end
				end
				OP_BEQ:  tk = a == b;
				OP_BNE:  tk = a != b;
				OP_BLEZ: tk = a[31] || a == 32'd0;
				default: tk = !a[31] && a != 32'd0;
			endcase
			arm = st == ST_CONTINUE;
		end else if (op == OP_SPECIAL) begin
			we = 1'b1;
			unique case (fn)
				FN_SLL:  wval = b << sa;
				FN_SRL:  wval = b >> sa;
				FN_SRA:  wval = $signed(b) >>> sa;
				FN_SLLV: wval = b << a[4:0];
				FN_SRLV: wval = b >> a[4:0];
				FN_SRAV: wval = $signed(b) >>> a[4:0];
				FN_SYSCALL: begin we = 1'b0; st = ST_SYSCALL; end
				FN_SYNC: we = 1'b0;
				FN_MFHI: wval = hi_q;
				FN_MTHI: begin we = 1'b0; hiwe = 1'b1; end
				FN_MFLO: wval = lo_q;
				FN_MTLO: begin we = 1'b0; lowe = 1'b1; end
				FN_MULT, FN_MULTU: begin we = 1'b0; md_start = 1'b1; end
				FN_DIV: begin
					we = 1'b0;
					if (b == 32'd0) begin
						hiwe = 1'b1; lowe = 1'b1; hival = a;
						loval = a[31] ? 32'd1 : 32'hFFFF_FFFF;
					end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
						hiwe = 1'b1; lowe = 1'b1; hival = '0; loval = 32'h8000_0000;
					end else begin
						md_start = 1'b1;
					end
				end
				FN_DIVU: begin
					we = 1'b0;
					if (b == 32'd0) begin
						hiwe = 1'b1; lowe = 1'b1; hival = a; loval = 32'hFFFF_FFFF;
					end else begin
						md_start = 1'b1;
					end
				end
				FN_ADD, FN_ADDU: wval = a + b;
				FN_SUB, FN_SUBU: wval = a - b;
				FN_AND:  wval = a & b;
				FN_OR:   wval = a | b;
				FN_XOR:  wval = a ^ b;
				FN_NOR:  wval = ~(a | b);
				FN_SLT:  wval = {31'd0, $signed(a) < $signed(b)};
				FN_SLTU: wval = {31'd0, a < b};
				default: begin we = 1'b0; st = ST_UNSUP; end
			endcase
		end else begin
			we = 1'b1; widx = rt;
			unique case (op)
				OP_ADDI, OP_ADDIU: wval = a + simm;
				OP_SLTI:  wval = {31'd0, $signed(a) < $signed(simm)};
				OP_SLTIU: wval = {31'd0, a < simm};
				OP_ANDI:  wval = a & imm;
				OP_ORI:   wval = a | imm;
				OP_XORI:  wval = a ^ imm;
				OP_LUI:   wval = {w[15:0], 16'd0};
				OP_COP0: begin
					if (rs == RS_MF) begin
						wval = c0_s1;
					end else if (rs == RS_MT) begin
						we = 1'b0; c0we = 1'b1;
					end else if (rs == RS_CO && fn == FN_RFE) begin
						we = 1'b0; c0we = 1'b1;
						c0val = {c0_s1[31:4], c0_s1[5:2]};
					end else begin
						we = 1'b0; st = ST_UNSUP;
					end
				end
				OP_COP2: begin we = 1'b0; st = (rs[4]) ? ST_COP2 : ST_UNSUP; end
				OP_CACHE: we = 1'b0;
				default: begin we = 1'b0; st = ST_UNSUP; end
			endcase
		end
		if (widx == 5'd0) we = 1'b0;
		if (st != ST_CONTINUE) nxt = pc;
		else if (bp_q)         nxt = bt_q ? btgt_q : pc4;
		else                   nxt = pc4;
	end

	// register file and COP0 storage, operand reads and capture of the current word
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			a_s1  <= gpr_ok_q[rs] ? gpr_q[rs] : 32'd0;
			b_s1  <= gpr_ok_q[rt] ? gpr_q[rt] : 32'd0;
			c0_s1 <= cp0_ok_q[(op == OP_COP0 && rs == RS_CO) ? CP0_SR : rd]
				? cp0_q[(op == OP_COP0 && rs == RS_CO) ? CP0_SR : rd] : 32'd0;
		end
		if (state_q == S_EXEC && out_free) begin
			if (we)   gpr_q[widx] <= wval;
			if (c0we) cp0_q[(rs == RS_CO) ? CP0_SR : rd] <= c0val;
		end
		if (state_q == S_IDLE && q_valid) cur_q <= q_data;
	end

	// sequencer, HI/LO, valid bits, branch state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			gpr_ok_q <= '0;
			cp0_ok_q <= '0;
			hi_q     <= '0;
			lo_q     <= '0;
			bp_q     <= 1'b0;
			bt_q     <= 1'b0;
			btgt_q   <= '0;
			out_v_q  <= 1'b0;
			out_data <= '0;
		end else begin
			if (out_load)            out_v_q <= 1'b1;
			else if (pop && out_v_q) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (q_valid) state_q <= S_READ;
				S_READ: state_q <= S_EXEC;
				S_EXEC: begin
					if (out_load) begin
						if (we)   gpr_ok_q[widx] <= 1'b1;
						if (c0we) cp0_ok_q[(rs == RS_CO) ? CP0_SR : rd] <= 1'b1;
						if (hiwe) hi_q <= hival;
						if (lowe) lo_q <= loval;
						bp_q   <= arm;
						bt_q   <= arm && tk;
						if (arm) btgt_q <= tgt;
						out_data.status    <= (st == ST_CONTINUE && bp_q) ? ST_DONE : st;
						out_data.next_pc   <= nxt;
						out_data.reg_write <= we;
						out_data.reg_index <= we ? widx : 5'd0;
						out_data.reg_value <= we ? wval : 32'd0;
						state_q <= S_IDLE;
					end else if (md_go) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (md_done) begin
						hi_q <= md_hi;
						lo_q <= md_lo;
						bp_q <= 1'b0;
						bt_q <= 1'b0;
						out_data.status    <= bp_q ? ST_DONE : ST_CONTINUE;
						out_data.next_pc   <= nxt;
						out_data.reg_write <= 1'b0;
						out_data.reg_index <= 5'd0;
						out_data.reg_value <= 32'd0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
